@@ sv/ctn_pkg.sv @@
// ----------------------------------------------------------------------------
// ctn_pkg
// Types, byte codes and byte-level helper functions of the confusable text
// normaliser.
// ----------------------------------------------------------------------------
package ctn_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int ADDR_W      = 3;

    localparam logic [0:0]  REG_MAX_OUTPUT_LEN = 1'b0;
    localparam logic [15:0] MAX_OUTPUT_LEN_RST = 16'hFFFF;

    localparam logic [7:0] BYTE_C2 = 8'hC2;
    localparam logic [7:0] BYTE_A0 = 8'hA0;
    localparam logic [7:0] BYTE_E2 = 8'hE2;
    localparam logic [7:0] BYTE_80 = 8'h80;
    localparam logic [7:0] BYTE_81 = 8'h81;
    localparam logic [7:0] BYTE_8D = 8'h8D;
    localparam logic [7:0] BYTE_A8 = 8'hA8;
    localparam logic [7:0] BYTE_A9 = 8'hA9;
    localparam logic [7:0] BYTE_AF = 8'hAF;
    localparam logic [7:0] BYTE_9F = 8'h9F;
    localparam logic [7:0] BYTE_E3 = 8'hE3;
    localparam logic [7:0] BYTE_EF = 8'hEF;
    localparam logic [7:0] BYTE_BB = 8'hBB;
    localparam logic [7:0] BYTE_BF = 8'hBF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        out_last;
        logic [15:0] total_len;
    } result_t;

    typedef struct packed {
        logic [7:0]  pend0;
        logic [7:0]  pend1;
        logic [1:0]  pend_count;
        logic [15:0] emitted;
    } scan_state_t;

    function automatic logic [1:0] lead_need(input logic [7:0] c);
        logic [1:0] need;
        need = 2'd1;
        if (c == BYTE_C2)
            need = 2'd2;
        else if (c == BYTE_E2 || c == BYTE_E3 || c == BYTE_EF)
            need = 2'd3;
        return need;
    endfunction

    function automatic logic [1:0] drop_len(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [1:0] avail);
        logic [1:0] len;
        len = 2'd0;
        if (avail >= 2'd2 && b0 == BYTE_C2 && b1 == BYTE_A0)
            len = 2'd2;
        else if (avail == 2'd3)
        begin
            if (b0 == BYTE_E2 && b1 == BYTE_80 && b2 >= BYTE_80 && b2 <= BYTE_8D)
                len = 2'd3;
            else if (b0 == BYTE_E2 && b1 == BYTE_80 &&
                     (b2 == BYTE_A8 || b2 == BYTE_A9 || b2 == BYTE_AF))
                len = 2'd3;
            else if (b0 == BYTE_E2 && b1 == BYTE_81 && b2 == BYTE_9F)
                len = 2'd3;
            else if (b0 == BYTE_E3 && b1 == BYTE_80 && b2 == BYTE_80)
                len = 2'd3;
            else if (b0 == BYTE_EF && b1 == BYTE_BB && b2 == BYTE_BF)
                len = 2'd3;
        end
        return len;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A);
    endfunction

    function automatic logic [7:0] map_byte(input logic [7:0] c);
        logic [7:0] m;
        case (c)
            8'h30:   m = 8'h6F;
            8'h31:   m = 8'h69;
            8'h33:   m = 8'h65;
            8'h34:   m = 8'h61;
            8'h35:   m = 8'h73;
            8'h37:   m = 8'h74;
            8'h40:   m = 8'h61;
            8'h24:   m = 8'h73;
            8'h21:   m = 8'h69;
            default: m = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
        endcase
        return m;
    endfunction

endpackage

@@ sv/ctn_scan.sv @@
// ----------------------------------------------------------------------------
// ctn_scan
// Scans the window of held bytes plus one new byte, drops invisible and
// blank sequences, maps the rest and gives up to three results per item.
// ----------------------------------------------------------------------------
module ctn_scan (
    input  ctn_pkg::item_t       item,
    input  ctn_pkg::scan_state_t cur,
    input  logic [15:0]          max_len,
    output ctn_pkg::result_t     results [ctn_pkg::MAX_RESULTS],
    output logic [1:0]           result_count,
    output ctn_pkg::scan_state_t nxt
);

    logic [7:0]       win [5];
    logic [1:0]       n;
    logic [1:0]       pos;
    logic [1:0]       avail;
    logic [1:0]       need;
    logic [1:0]       skip;
    logic [1:0]       cnt;
    logic [2:0]       idx1;
    logic [2:0]       idx2;
    logic [7:0]       c;
    logic [15:0]      emit;
    logic             done;
    ctn_pkg::result_t res [ctn_pkg::MAX_RESULTS];

    always_comb
    begin
        for (int w = 0; w < 5; w++)
            win[w] = '0;
        case (cur.pend_count)
            2'd0:
            begin
                win[0] = item.in_byte;
                n      = 2'd1;
            end
            2'd1:
            begin
                win[0] = cur.pend0;
                win[1] = item.in_byte;
                n      = 2'd2;
            end
            default:
            begin
                win[0] = cur.pend0;
                win[1] = cur.pend1;
                win[2] = item.in_byte;
                n      = 2'd3;
            end
        endcase

        pos   = '0;
        done  = 1'b0;
        emit  = cur.emitted;
        cnt   = '0;
        c     = '0;
        avail = '0;
        need  = '0;
        skip  = '0;
        idx1  = '0;
        idx2  = '0;
        for (int r = 0; r < ctn_pkg::MAX_RESULTS; r++)
            res[r] = '0;

        for (int k = 0; k < 3; k++)
        begin
            if (!done && pos < n)
            begin
                c     = win[{1'b0, pos}];
                avail = n - pos;
                idx1  = {1'b0, pos} + 3'd1;
                idx2  = {1'b0, pos} + 3'd2;
                if (emit >= max_len)
                begin
                    pos  = n;
                    done = 1'b1;
                end
                else
                begin
                    need = ctn_pkg::lead_need(c);
                    if (avail < need && !item.in_last)
                        done = 1'b1;
                    else
                    begin
                        skip = ctn_pkg::drop_len(c, win[idx1], win[idx2], avail);
                        if (skip != 2'd0)
                            pos = pos + skip;
                        else
                        begin
                            pos = pos + 2'd1;
                            if (!ctn_pkg::is_blank(c))
                            begin
                                emit = emit + 16'd1;
                                res[cnt].out_byte   = ctn_pkg::map_byte(c);
                                res[cnt].byte_valid = 1'b1;
                                res[cnt].out_last   = 1'b0;
                                res[cnt].total_len  = emit;
                                cnt = cnt + 2'd1;
                            end
                        end
                    end
                end
            end
        end

        idx1     = {1'b0, pos} + 3'd1;
        nxt.pend0 = win[{1'b0, pos}];
        nxt.pend1 = win[idx1];
        if (item.in_last)
        begin
            nxt.pend_count = '0;
            nxt.emitted    = '0;
            if (cnt == 2'd0)
            begin
                res[0].out_byte   = '0;
                res[0].byte_valid = 1'b0;
                res[0].out_last   = 1'b1;
                res[0].total_len  = emit;
                cnt = 2'd1;
            end
            else
                res[cnt - 2'd1].out_last = 1'b1;
        end
        else
        begin
            nxt.pend_count = n - pos;
            nxt.emitted    = emit;
        end

        results      = res;
        result_count = cnt;
    end

endmodule

@@ sv/ctn_result_fifo.sv @@
// ----------------------------------------------------------------------------
// ctn_result_fifo
// Result queue: takes up to three results per cycle, hands out one result per
// output handshake.
// ----------------------------------------------------------------------------
module ctn_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 push_count,
    input  ctn_pkg::result_t           push_data [ctn_pkg::MAX_RESULTS],
    output logic [$clog2(DEPTH+1)-1:0] free_slots,
    output logic                       result_valid,
    input  logic                       result_ready,
    output ctn_pkg::result_t           result
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ctn_pkg::result_t   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [PTR_W-1:0]   wr_idx [ctn_pkg::MAX_RESULTS + 1];
    logic [PTR_W:0]     sum;
    logic               pop;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i <= ctn_pkg::MAX_RESULTS; i++)
        begin
            sum = {1'b0, wr_ptr_reg} + (PTR_W+1)'(i);
            if (sum >= (PTR_W+1)'(DEPTH))
                sum = sum - (PTR_W+1)'(DEPTH);
            wr_idx[i] = sum[PTR_W-1:0];
        end
    end

    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign result       = mem[rd_ptr_reg];
    assign free_slots   = CNT_W'(DEPTH) - count_reg;
    assign wr_ptr_next  = wr_idx[push_count];
    assign rd_ptr_next  = pop ? ((rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1)
                              : rd_ptr_reg;
    assign count_next   = count_reg + CNT_W'(push_count) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ctn_pkg::MAX_RESULTS; i++)
        begin
            if (2'(i) < push_count)
                mem[wr_idx[i]] <= push_data[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/confusable_text_normalizer_unit.sv @@
// ----------------------------------------------------------------------------
// confusable_text_normalizer_unit
// Byte-stream normaliser: drops invisible and blank UTF-8 sequences, maps
// look-alike characters and folds upper case, with an output length limit.
// ----------------------------------------------------------------------------
// Items are registered in item_reg; their results leave through the result queue.
// Throughput: one item per cycle while the result queue has room for the
//   item's results (up to three); one result leaves per cycle with result_ready.
// Reset: rst_n clears held bytes, counts and queue; max_output_len to 65535.
module confusable_text_normalizer_unit #(
    parameter int RESULT_DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  ctn_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output ctn_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ctn_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

    ctn_pkg::item_t       item_reg;
    logic                 item_vld_reg;
    logic                 item_vld_next;
    ctn_pkg::scan_state_t state_reg;
    ctn_pkg::scan_state_t state_next;
    logic [15:0]          max_len_reg;
    ctn_pkg::result_t     scan_results [ctn_pkg::MAX_RESULTS];
    logic [1:0]           scan_count;
    logic [1:0]           push_count;
    logic [CNT_W-1:0]     free_slots;
    logic                 fire;
    logic                 accept;
    logic                 cfg_write;
    logic [ctn_pkg::ADDR_W-3:0] reg_index;

    ctn_scan u_scan (
        .item         (item_reg),
        .cur          (state_reg),
        .max_len      (max_len_reg),
        .results      (scan_results),
        .result_count (scan_count),
        .nxt          (state_next)
    );

    ctn_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (push_count),
        .push_data    (scan_results),
        .free_slots   (free_slots),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assign fire          = item_vld_reg && (CNT_W'(scan_count) <= free_slots);
    assign push_count    = fire ? scan_count : 2'd0;
    assign item_ready    = !item_vld_reg || fire;
    assign accept        = item_valid && item_ready;
    assign item_vld_next = accept ? 1'b1 : (fire ? 1'b0 : item_vld_reg);

    assign pready    = 1'b1;
    assign reg_index = paddr[ctn_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite &&
                       (reg_index == ctn_pkg::REG_MAX_OUTPUT_LEN);

    always_comb
    begin
        prdata = '0;
        if (reg_index == ctn_pkg::REG_MAX_OUTPUT_LEN)
            prdata = {16'd0, max_len_reg};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            state_reg    <= '0;
            max_len_reg  <= ctn_pkg::MAX_OUTPUT_LEN_RST;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            if (fire)
                state_reg <= state_next;
            if (cfg_write)
                max_len_reg <= pwdata[15:0];
        end
    end

endmodule
